// ----- rtl/i2cts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cts_pkg
// Types, status codes and defaults shared by the I2C transfer sequencer.
// ----------------------------------------------------------------------------
package i2cts_pkg;

  localparam int BUFFER_BYTES_DEF = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] STATUS_MASK   = 8'hF8;
  localparam logic [7:0] ST_START      = 8'h08;
  localparam logic [7:0] ST_REP_START  = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
  localparam logic [7:0] ST_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_ARB_LOST   = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
  localparam logic [7:0] ST_RX_ACK     = 8'h50;
  localparam logic [7:0] ST_RX_NACK    = 8'h58;

  typedef enum logic [1:0] {
    XFER_NONE = 2'd0,
    XFER_OK   = 2'd1,
    XFER_FAIL = 2'd2
  } xfer_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] index;
    logic [7:0] data_byte;
    logic [4:0] msg_size;
    logic [7:0] bus_status;
  } in_item_t;

  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic       send_ack;
    logic       clear_flag;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic [1:0] transfer_state;
    logic [7:0] error_status;
    logic       busy_res;
    logic       write_delay_start;
  } out_item_t;

  typedef struct packed {
    xfer_e      state_code;
    logic [7:0] failure_code;
    logic       busy;
  } ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/i2c_master_transfer_sequencer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// I2C master message sequencer with message buffer and status decoding.
// ----------------------------------------------------------------------------
// Usage: each input item is one operation (load a buffer byte, start a
// transfer, report a bus status event, or read a buffer byte). Every item
// yields exactly one result item with the control word for the bus engine,
// the next transmit byte, the read byte and the transfer state.
// An item is taken when in_valid_i is high and in_stall_o is low; a result is
// taken when out_valid_o is high and out_stall_i is low.
// The item is captured in the input register, then the step logic updates
// the state and the buffer RAM read port while the result register is
// loaded. One item per cycle is sustained while the receiver does not
// stall, set by the single buffer RAM read port and the step logic.
// At reset the pointer, length, transfer state, failure code and busy flag
// are cleared. The message buffer is not cleared; a byte must be loaded
// before it is sent or read back.
// When the receiver stalls, the result is held; one more item is captured
// in the input register and then in_stall_o is raised until the result
// drains.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core #(
  parameter int BUFFER_BYTES = i2cts_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire i2cts_pkg::in_item_t in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output i2cts_pkg::out_item_t  out_item_o
);

  localparam int PTR_W = $clog2(BUFFER_BYTES + 1);
  localparam int AW    = $clog2(BUFFER_BYTES);

  logic                 in_valid_q, in_valid_d;
  i2cts_pkg::in_item_t  item_q;
  logic                 out_valid_q, out_valid_d;
  i2cts_pkg::out_item_t res_q;
  logic                 rd_sel_q;
  i2cts_pkg::ctrl_t     ctrl_q, ctrl_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [PTR_W-1:0]     len_q, len_d;

  i2cts_pkg::out_item_t res_d;
  logic                 rd_sel_d;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [7:0]           ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 fire;
  logic                 in_accept;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : ((out_valid_q && out_stall_i) ? 1'b1 : 1'b0);
  assign out_valid_o = out_valid_q;

  i2cts_step #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_step (
    .item_i  (item_q),
    .ctrl_i  (ctrl_q),
    .ptr_i   (ptr_q),
    .len_i   (len_q),
    .ctrl_o  (ctrl_d),
    .ptr_o   (ptr_d),
    .len_o   (len_d),
    .res_o   (res_d),
    .rd_sel_o(rd_sel_d),
    .we_o    (ram_we),
    .waddr_o (ram_waddr),
    .wdata_o (ram_wdata),
    .raddr_o (ram_raddr)
  );

  i2cts_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buffer (
    .clk_i  (clk_i),
    .we_i   (fire && ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (fire),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= '{state_code: i2cts_pkg::XFER_NONE, failure_code: '0, busy: 1'b0};
      ptr_q       <= '0;
      len_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        ctrl_q <= ctrl_d;
        ptr_q  <= ptr_d;
        len_q  <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    if (fire) begin
      res_q    <= res_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  always_comb begin
    out_item_o           = res_q;
    out_item_o.tx_byte   = res_q.tx_valid ? ram_rdata : 8'h00;
    out_item_o.read_data = rd_sel_q ? ram_rdata : 8'h00;
  end

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(BUFFER_BYTES))
    else $error("Byte pointer exceeds the buffer size.");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PTR_W'(BUFFER_BYTES))
    else $error("Message length exceeds the buffer size.");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (item_q.operation == i2cts_pkg::OP_START) && !ctrl_q.busy)
      |=> (ctrl_q.busy && out_valid_q && res_q.issue_start))
    else $error("Start item did not set busy and issue a start.");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("Input stalled without a pending item and result.");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("Processed item did not produce a result.");

endmodule
`default_nettype wire

// ----- rtl/i2cts_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module i2cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2cts_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cts_step
// Next-state and control-word logic for one operation of the sequencer.
// ----------------------------------------------------------------------------
module i2cts_step #(
  parameter int BUFFER_BYTES = i2cts_pkg::BUFFER_BYTES_DEF
) (
  input  wire i2cts_pkg::in_item_t                item_i,
  input  wire i2cts_pkg::ctrl_t                   ctrl_i,
  input  wire logic [$clog2(BUFFER_BYTES+1)-1:0]  ptr_i,
  input  wire logic [$clog2(BUFFER_BYTES+1)-1:0]  len_i,
  output i2cts_pkg::ctrl_t                        ctrl_o,
  output logic      [$clog2(BUFFER_BYTES+1)-1:0]  ptr_o,
  output logic      [$clog2(BUFFER_BYTES+1)-1:0]  len_o,
  output i2cts_pkg::out_item_t                    res_o,
  output logic                                    rd_sel_o,
  output logic                                    we_o,
  output logic      [$clog2(BUFFER_BYTES)-1:0]    waddr_o,
  output logic      [7:0]                         wdata_o,
  output logic      [$clog2(BUFFER_BYTES)-1:0]    raddr_o
);

  localparam int PTR_W = $clog2(BUFFER_BYTES + 1);
  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int SW    = (PTR_W > 5) ? PTR_W : 5;
  localparam logic [SW-1:0] BUF_N = SW'(BUFFER_BYTES);

  logic [SW-1:0] ptr_w;
  logic [SW-1:0] len_w;
  logic [SW-1:0] idx_w;
  logic [SW-1:0] size_w;
  logic [SW-1:0] ptr_eff;
  logic [SW-1:0] ptr_n;
  logic [SW-1:0] len_n;
  logic [7:0]    stat;

  assign ptr_w  = SW'(ptr_i);
  assign len_w  = SW'(len_i);
  assign idx_w  = SW'(item_i.index);
  assign size_w = SW'(item_i.msg_size);
  assign stat   = item_i.bus_status & i2cts_pkg::STATUS_MASK;
  assign ptr_o  = ptr_n[PTR_W-1:0];
  assign len_o  = len_n[PTR_W-1:0];

  always_comb begin
    ctrl_o   = ctrl_i;
    ptr_n    = ptr_w;
    len_n    = len_w;
    ptr_eff  = ptr_w;
    res_o    = '0;
    rd_sel_o = 1'b0;
    we_o     = 1'b0;
    waddr_o  = idx_w[AW-1:0];
    wdata_o  = item_i.data_byte;
    raddr_o  = idx_w[AW-1:0];

    case (item_i.operation)
      i2cts_pkg::OP_LOAD: begin
        if (!ctrl_i.busy && (idx_w < BUF_N)) begin
          we_o = 1'b1;
        end
      end
      i2cts_pkg::OP_START: begin
        if (!ctrl_i.busy) begin
          len_n               = (size_w > BUF_N) ? BUF_N : size_w;
          ctrl_o.state_code   = i2cts_pkg::XFER_NONE;
          ctrl_o.failure_code = '0;
          ctrl_o.busy         = 1'b1;
          res_o.issue_start   = 1'b1;
          res_o.clear_flag    = 1'b1;
        end
      end
      i2cts_pkg::OP_EVENT: begin
        if (ctrl_i.busy) begin
          case (stat)
            i2cts_pkg::ST_START, i2cts_pkg::ST_REP_START,
            i2cts_pkg::ST_SLA_W_ACK, i2cts_pkg::ST_DATA_ACK: begin
              if ((stat == i2cts_pkg::ST_START) || (stat == i2cts_pkg::ST_REP_START)) begin
                ptr_eff = '0;
              end
              ptr_n = ptr_eff;
              if (ptr_eff < len_w) begin
                raddr_o          = ptr_eff[AW-1:0];
                res_o.tx_valid   = 1'b1;
                res_o.clear_flag = 1'b1;
                ptr_n            = ptr_eff + SW'(1);
              end else begin
                ctrl_o.state_code       = i2cts_pkg::XFER_OK;
                ctrl_o.busy             = 1'b0;
                res_o.issue_stop        = 1'b1;
                res_o.clear_flag        = 1'b1;
                res_o.write_delay_start = 1'b1;
              end
            end
            i2cts_pkg::ST_RX_ACK, i2cts_pkg::ST_SLA_R_ACK: begin
              if ((stat == i2cts_pkg::ST_RX_ACK) && (ptr_w < BUF_N)) begin
                we_o    = 1'b1;
                waddr_o = ptr_w[AW-1:0];
                ptr_n   = ptr_w + SW'(1);
              end
              res_o.clear_flag = 1'b1;
              res_o.send_ack   = (({1'b0, ptr_n} + (SW+1)'(1)) < {1'b0, len_w});
            end
            i2cts_pkg::ST_RX_NACK: begin
              if (ptr_w < BUF_N) begin
                we_o    = 1'b1;
                waddr_o = ptr_w[AW-1:0];
              end
              ctrl_o.state_code = i2cts_pkg::XFER_OK;
              ctrl_o.busy       = 1'b0;
              res_o.issue_stop  = 1'b1;
              res_o.clear_flag  = 1'b1;
            end
            i2cts_pkg::ST_ARB_LOST: begin
              res_o.issue_start = 1'b1;
              res_o.clear_flag  = 1'b1;
            end
            default: begin
              ctrl_o.state_code   = i2cts_pkg::XFER_FAIL;
              ctrl_o.failure_code = stat;
              ctrl_o.busy         = 1'b0;
            end
          endcase
        end
      end
      i2cts_pkg::OP_READ: begin
        if (!ctrl_i.busy && (ctrl_i.state_code == i2cts_pkg::XFER_OK) && (idx_w < BUF_N)) begin
          rd_sel_o = 1'b1;
        end
      end
      default: begin
        ctrl_o = ctrl_i;
      end
    endcase

    res_o.transfer_state = 2'(ctrl_o.state_code);
    res_o.error_status   = ctrl_o.failure_code;
    res_o.busy_res       = ctrl_o.busy;
  end

endmodule
`default_nettype wire

// ----- verif/tb_i2c_master_transfer_sequencer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer_core
// Self-checking testbench for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
// A short table of directed items runs first. It covers masked status codes,
// zero and oversized message lengths, arbitration loss, error status, and
// operations that the block ignores. A long random run of load, start, event
// and read items follows. Every result item is compared field by field with a
// prediction made inside the testbench or typed into the directed table. Both
// sides idle and stall at random, except for one long stretch with no idling.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer_core;
  import i2cts_pkg::*;

  localparam int NBYTES       = BUFFER_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 27;
  localparam int PRINT_CAP    = 40;
  localparam int DIR_ROWS     = 26;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam out_item_t W_QUIET = '0;
  localparam out_item_t W_START = {1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00,
                                   XFER_NONE, 8'h00, 1'b1, 1'b0};
  localparam out_item_t W_FAIL  = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00,
                                   XFER_FAIL, 8'hF8, 1'b0, 1'b0};

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Predicted state of the sequencer.
  logic [7:0] seq_buf [NBYTES];
  bit         seq_written [NBYTES];
  int         seq_ptr   = 0;
  int         seq_len   = 0;
  xfer_e      seq_state = XFER_NONE;
  logic [7:0] seq_fail  = 8'h00;
  logic       seq_busy  = 1'b0;

  out_item_t bus_responses [$];
  out_item_t want;
  int        error_count  = 0;
  int        result_count = 0;
  int        cycle_count  = 0;
  bit        quiet_phase  = 1'b0;

  i2c_master_transfer_sequencer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp_val);
    if (got !== exp_val) begin
      report_error($sformatf("result %0d %s: got %0h, expected %0h",
                             result_count, name, got, exp_val));
    end
  endtask

  task automatic sequence_step(input in_item_t it, output out_item_t r);
    logic [7:0] status;
    status = it.bus_status & STATUS_MASK;
    r = '0;
    case (it.operation)
      OP_LOAD: begin
        if (!seq_busy && int'(it.index) < NBYTES) begin
          seq_buf[it.index] = it.data_byte;
          seq_written[it.index] = 1'b1;
        end
      end
      OP_START: begin
        if (!seq_busy) begin
          seq_len = (int'(it.msg_size) > NBYTES) ? NBYTES : int'(it.msg_size);
          seq_state = XFER_NONE;
          seq_fail = 8'h00;
          seq_busy = 1'b1;
          r.issue_start = 1'b1;
          r.clear_flag = 1'b1;
        end
      end
      OP_EVENT: begin
        if (seq_busy) begin
          case (status)
            ST_START, ST_REP_START, ST_SLA_W_ACK, ST_DATA_ACK: begin
              if (status == ST_START || status == ST_REP_START) begin
                seq_ptr = 0;
              end
              if (seq_ptr < seq_len && seq_ptr < NBYTES) begin
                r.tx_byte = seq_buf[seq_ptr];
                r.tx_valid = 1'b1;
                r.clear_flag = 1'b1;
                seq_ptr++;
              end else begin
                seq_state = XFER_OK;
                r.issue_stop = 1'b1;
                r.clear_flag = 1'b1;
                seq_busy = 1'b0;
                r.write_delay_start = 1'b1;
              end
            end
            ST_RX_ACK, ST_SLA_R_ACK: begin
              if (status == ST_RX_ACK && seq_ptr < NBYTES) begin
                seq_buf[seq_ptr] = it.data_byte;
                seq_written[seq_ptr] = 1'b1;
                seq_ptr++;
              end
              r.clear_flag = 1'b1;
              if (seq_len > 0 && seq_ptr < seq_len - 1) begin
                r.send_ack = 1'b1;
              end
            end
            ST_RX_NACK: begin
              if (seq_ptr < NBYTES) begin
                seq_buf[seq_ptr] = it.data_byte;
                seq_written[seq_ptr] = 1'b1;
              end
              seq_state = XFER_OK;
              r.issue_stop = 1'b1;
              r.clear_flag = 1'b1;
              seq_busy = 1'b0;
            end
            ST_ARB_LOST: begin
              r.issue_start = 1'b1;
              r.clear_flag = 1'b1;
            end
            default: begin
              seq_state = XFER_FAIL;
              seq_fail = status;
              seq_busy = 1'b0;
            end
          endcase
        end
      end
      default: begin
        if (!seq_busy && seq_state == XFER_OK && int'(it.index) < NBYTES) begin
          r.read_data = seq_buf[it.index];
        end
      end
    endcase
    r.transfer_state = seq_state;
    r.error_status = seq_fail;
    r.busy_res = seq_busy;
  endtask

  // Holds the item until it is taken; an idle gap may come first.
  task automatic send_item(input in_item_t it);
    while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_responses.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = bus_responses.pop_front();
        check_field("issue_start", out_item_o.issue_start, want.issue_start);
        check_field("issue_stop", out_item_o.issue_stop, want.issue_stop);
        check_field("send_ack", out_item_o.send_ack, want.send_ack);
        check_field("clear_flag", out_item_o.clear_flag, want.clear_flag);
        check_field("tx_valid", out_item_o.tx_valid, want.tx_valid);
        check_field("tx_byte", out_item_o.tx_byte, want.tx_byte);
        check_field("read_data", out_item_o.read_data, want.read_data);
        check_field("transfer_state", out_item_o.transfer_state, want.transfer_state);
        check_field("error_status", out_item_o.error_status, want.error_status);
        check_field("busy_res", out_item_o.busy_res, want.busy_res);
        check_field("write_delay_start", out_item_o.write_delay_start,
                    want.write_delay_start);
      end
      result_count++;
    end
    out_stall_i <= !quiet_phase && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t   plan [DIR_ROWS];
    in_item_t   it;
    out_item_t  predicted;
    logic [7:0] masked;
    logic [7:0] code;
    int         pick;
    int         p;
    int         counted;
    bit         skipped;
    bit         fresh;
    bit         rx_mode;

    counted = 0;
    fresh = 1'b0;
    rx_mode = 1'b0;
    plan = '{
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  ST_START, TYPED, W_QUIET},
      {OP_READ,  4'd0,  8'h00, 5'd0,  8'h00,    TYPED, W_QUIET},
      {OP_LOAD,  4'd0,  8'hA0, 5'd0,  8'h00,    TYPED, W_QUIET},
      {OP_LOAD,  4'd1,  8'hFF, 5'd0,  8'h00,    TYPED, W_QUIET},
      {OP_LOAD,  4'd2,  8'h00, 5'd0,  8'h00,    TYPED, W_QUIET},
      {OP_LOAD,  4'd15, 8'h5A, 5'd0,  8'h00,    TYPED, W_QUIET},
      {OP_START, 4'd0,  8'h00, 5'd3,  8'h00,    TYPED, W_START},
      {OP_LOAD,  4'd3,  8'h77, 5'd0,  8'h00,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h08,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h1F,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h28,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h2F,    PREDICTED, W_QUIET},
      {OP_READ,  4'd1,  8'h00, 5'd0,  8'h00,    PREDICTED, W_QUIET},
      {OP_START, 4'd0,  8'h00, 5'd31, 8'h00,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h3B,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h10,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h40,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h3C, 5'd0,  8'h54,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'hC3, 5'd0,  8'h58,    PREDICTED, W_QUIET},
      {OP_READ,  4'd2,  8'h00, 5'd0,  8'h00,    PREDICTED, W_QUIET},
      {OP_START, 4'd0,  8'h00, 5'd0,  8'h00,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h18,    PREDICTED, W_QUIET},
      {OP_START, 4'd0,  8'hFF, 5'd0,  8'hFF,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd0,  8'h00, 5'd0,  8'h40,    PREDICTED, W_QUIET},
      {OP_EVENT, 4'd15, 8'hFF, 5'd31, 8'hFF,    TYPED, W_FAIL},
      {OP_READ,  4'd0,  8'h00, 5'd0,  8'h00,    TYPED, W_FAIL}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIR_ROWS; n++) begin
      sequence_step(plan[n].item, predicted);
      bus_responses.push_back(plan[n].typed ? plan[n].res : predicted);
      send_item(plan[n].item);
    end

    // Random part: well-formed transmit and receive transfers with random
    // content, mixed with stray status codes and stray operations.
    while (counted < RANDOM_ITEMS) begin
      quiet_phase = (counted >= 700 && counted < 1000);
      pick = $urandom_range(0, 99);
      it.operation = OP_EVENT;
      it.index = 4'($urandom_range(0, 15));
      it.data_byte = 8'($urandom_range(0, 255));
      it.msg_size = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                : 5'($urandom_range(0, 16));
      code = 8'($urandom_range(0, 255));
      if (!seq_busy) begin
        if (pick < 35) begin
          it.operation = OP_LOAD;
        end else if (pick < 50) begin
          it.operation = OP_START;
          rx_mode = 1'($urandom_range(0, 1));
          fresh = 1'b1;
        end else if (pick < 90) begin
          it.operation = OP_READ;
        end
      end else if (pick >= 96) begin
        it.operation = 2'($urandom_range(0, 3));
      end else if (fresh && pick < 85) begin
        code = ($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START;
      end else if (pick < 4) begin
        code = code;
      end else if (pick < 8) begin
        code = ST_ARB_LOST;
      end else if (pick < 14) begin
        code = ($urandom_range(0, 1) == 0) ? ST_REP_START : ST_START;
      end else if (!rx_mode) begin
        code = ($urandom_range(0, 1) == 0) ? ST_SLA_W_ACK : ST_DATA_ACK;
      end else if (pick < 20) begin
        code = ST_SLA_R_ACK;
      end else if (pick < 92) begin
        code = ST_RX_ACK;
      end else begin
        code = ST_RX_NACK;
      end
      it.bus_status = code | 8'($urandom_range(0, 7));
      if (it.operation == OP_EVENT && seq_busy) begin
        fresh = 1'b0;
      end

      // Never send or read back a buffer byte that was never written.
      masked = it.bus_status & STATUS_MASK;
      if (it.operation == OP_READ && !seq_busy && seq_state == XFER_OK &&
          !seq_written[it.index]) begin
        it.operation = OP_LOAD;
      end
      if (it.operation == OP_EVENT && seq_busy &&
          (masked == ST_START || masked == ST_REP_START ||
           masked == ST_SLA_W_ACK || masked == ST_DATA_ACK)) begin
        p = (masked == ST_START || masked == ST_REP_START) ? 0 : seq_ptr;
        if (p < seq_len && p < NBYTES && !seq_written[p]) begin
          it.bus_status = ST_ARB_LOST;
        end
      end

      skipped = (it.operation == OP_EVENT && !seq_busy) ||
                ((it.operation == OP_LOAD || it.operation == OP_START) && seq_busy);
      sequence_step(it, predicted);
      bus_responses.push_back(predicted);
      send_item(it);
      if (!skipped) begin
        counted++;
      end
    end
    in_valid_i <= 1'b0;

    while (bus_responses.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/i2cts_pkg.sv
rtl/i2cts_ram.sv
rtl/i2cts_step.sv
rtl/i2c_master_transfer_sequencer_core.sv
verif/tb_i2c_master_transfer_sequencer_core.sv
